// ===== hdl/rbc_pkg.sv =====
`timescale 1ns / 1ps
package rbc_pkg;

  localparam int COEF_WIDTH_DEF  = 32;
  localparam int STATE_WIDTH_DEF = 24;
  localparam int NUM_WIDTH       = 20;
  localparam int Q_WIDTH         = 15;
  localparam int CLIP_DIVISOR    = 17;
  localparam int CLIP_MULT       = 28;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_HP_B0   = 3'd1,
    REG_HP_A1   = 3'd2,
    REG_HP_A2   = 3'd3,
    REG_LP_B0   = 3'd4,
    REG_LP_A1   = 3'd5,
    REG_LP_A2   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mac_ctrl_t;

endpackage

// ===== hdl/rbc_mac.sv =====
`timescale 1ns / 1ps
module rbc_mac #(
  parameter int CW = rbc_pkg::COEF_WIDTH_DEF,
  parameter int MW = rbc_pkg::STATE_WIDTH_DEF + 2,
  parameter int AW = rbc_pkg::COEF_WIDTH_DEF + rbc_pkg::STATE_WIDTH_DEF + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rbc_pkg::mac_ctrl_t   ctrl,
  input  logic signed [CW-1:0] coef,
  input  logic signed [MW-1:0] mult,
  output logic signed [AW-1:0] acc,
  output logic                 done
);
  import rbc_pkg::*;

  localparam int CNW = $clog2(MW);

  logic signed [AW-1:0] creg;
  logic [MW-1:0]        mreg;
  logic [CNW-1:0]       cnt;
  logic                 busy;
  logic                 sub;
  logic                 neg;
  logic                 last_bit;

  assign last_bit = (cnt == CNW'(MW - 1));
  assign neg = sub ^ last_bit;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      creg <= AW'(coef);
      mreg <= mult;
      sub  <= ctrl.sub;
      cnt  <= '0;
      busy <= 1'b1;
      if (ctrl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mreg[0]) begin
        acc <= neg ? acc - creg : acc + creg;
      end
      creg <= creg <<< 1;
      mreg <= mreg >> 1;
      cnt  <= cnt + 1'b1;
      if (last_bit) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rbc_div.sv =====
`timescale 1ns / 1ps
module rbc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rbc_pkg::NUM_WIDTH-1:0] num,
  output logic [rbc_pkg::Q_WIDTH-1:0]   quot,
  output logic                          done
);
  import rbc_pkg::*;

  localparam int CNW = $clog2(NUM_WIDTH);

  logic [NUM_WIDTH-1:0] nreg;
  logic [4:0]           rem;
  logic [5:0]           trial;
  logic                 qbit;
  logic [CNW-1:0]       cnt;
  logic                 busy;

  // long division by seventeen, one numerator bit per cycle
  assign trial = {rem, nreg[NUM_WIDTH-1]};
  assign qbit  = (trial >= 6'(CLIP_DIVISOR));
  assign quot  = nreg[Q_WIDTH-1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      nreg <= num;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= qbit ? 5'(trial - 6'(CLIP_DIVISOR)) : trial[4:0];
      nreg <= {nreg[NUM_WIDTH-2:0], qbit};
      cnt  <= cnt + 1'b1;
      if (cnt == CNW'(NUM_WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/radio_bandpass_clip_effect_core.sv =====
`timescale 1ns / 1ps
// radio voice effect: high-pass then low-pass biquad, gain, hard clip
// input stream s_*: one signed 16-bit sample per transfer, s_tlast ends a clip
// output stream m_*: one processed sample per input transfer, m_tlast copied
// apb port writes enable and the six filter coefficients (regs at 4*i, 8*i when COEF_WIDTH > 32)
// with the effect off the sample passes straight from the idle state to the output state
// and the next sample is taken only after its result is posted
// with the effect on each biquad runs three bit-serial multiply terms on one
// shared shift-add unit, then a scale state and a serial divide by seventeen;
// the divide is skipped when the output clips
// one sample is in work at a time; s_tready is high only when idle, which the
// core reaches as the result is posted
// a finished sample sits in the output register while the next is taken;
// if m_tready stays low the core holds the next result until it is free
// a clip end clears all filter history after its own sample is formed
// reset clears the registers, the history and the output valid
module radio_bandpass_clip_effect_core #(
  parameter int COEF_WIDTH  = rbc_pkg::COEF_WIDTH_DEF,
  parameter int STATE_WIDTH = rbc_pkg::STATE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,  // sample_in
  input  logic                                s_tlast,  // last_in_clip
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,  // sample_out
  output logic                                m_tlast,  // last_out
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [((COEF_WIDTH > 32) ? 6 : 5)-1:0]  paddr,
  input  logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                pready
);
  import rbc_pkg::*;

  localparam int CW = COEF_WIDTH;
  localparam int SW = STATE_WIDTH;
  localparam int CF = CW - 3;
  localparam int SF = SW - 4;
  localparam int MW = SW + 2;
  localparam int AW = CW + SW + 4;
  localparam int DW = (CW > 32) ? 64 : 32;
  localparam int AB = (CW > 32) ? 6 : 5;
  localparam int AS = (CW > 32) ? 3 : 2;
  localparam int UP = SF - 15;
  localparam int NW = SW + 20;
  localparam logic signed [AW-1:0] SMAX = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
  localparam logic [SW+4:0] CLIP_LEVEL = (SW + 5)'(CLIP_DIVISOR) << SF;

  logic                 en;
  logic signed [CW-1:0] hp_b0, hp_a1, hp_a2, lp_b0, lp_a1, lp_a2;
  logic signed [SW-1:0] hx1, hx2, hy1, hy2, lx1, lx2, ly1, ly2;
  logic signed [SW-1:0] cur_x;
  logic                 last;
  logic                 stage;
  logic [1:0]           tc;
  logic [15:0]          res;
  ctrl_state_t          state, state_next;

  logic [2:0]           widx;
  logic                 wr;

  mac_ctrl_t            mctrl;
  logic signed [CW-1:0] mcoef;
  logic signed [MW-1:0] mmult;
  logic signed [MW-1:0] ff;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_sh;
  logic signed [SW-1:0] yv;
  logic                 mdone;

  logic                 dstart;
  logic [Q_WIDTH-1:0]   quot;
  logic                 ddone;

  logic signed [SW+15:0] xw;
  logic signed [SW-1:0]  xin;
  logic [SW-1:0]         mag;
  logic [SW+4:0]         m28;
  logic                  clip;
  logic [NW-1:0]         numw;
  logic [NW-1:0]         nsh;
  logic                  out_free;

  // register port
  assign pready = 1'b1;
  assign widx   = paddr[AB-1:AS];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      en    <= 1'b0;
      hp_b0 <= '0;
      hp_a1 <= '0;
      hp_a2 <= '0;
      lp_b0 <= '0;
      lp_a1 <= '0;
      lp_a2 <= '0;
    end else if (wr) begin
      case (widx)
        REG_ENABLE: en    <= pwdata[0];
        REG_HP_B0:  hp_b0 <= pwdata[CW-1:0];
        REG_HP_A1:  hp_a1 <= pwdata[CW-1:0];
        REG_HP_A2:  hp_a2 <= pwdata[CW-1:0];
        REG_LP_B0:  lp_b0 <= pwdata[CW-1:0];
        REG_LP_A1:  lp_a1 <= pwdata[CW-1:0];
        REG_LP_A2:  lp_a2 <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ENABLE: prdata = DW'(en);
      REG_HP_B0:  prdata = DW'(hp_b0);
      REG_HP_A1:  prdata = DW'(hp_a1);
      REG_HP_A2:  prdata = DW'(hp_a2);
      REG_LP_B0:  prdata = DW'(lp_b0);
      REG_LP_A1:  prdata = DW'(lp_a1);
      REG_LP_A2:  prdata = DW'(lp_a2);
      default:    prdata = '0;
    endcase
  end

  // input scaling to the state format
  always_comb begin
    xw = (SW + 16)'($signed(s_tdata));
    if (UP >= 0) begin
      xw = xw <<< ((UP >= 0) ? UP : 0);
    end else begin
      xw = xw >>> 1;
    end
    xin = xw[SW-1:0];
  end

  // operand select for the shared multiply unit
  always_comb begin
    if (stage) begin
      ff = MW'(cur_x) + (MW'(lx1) <<< 1) + MW'(lx2);
    end else begin
      ff = MW'(cur_x) - (MW'(hx1) <<< 1) + MW'(hx2);
    end
    case (tc)
      2'd0: begin
        mcoef = stage ? lp_b0 : hp_b0;
        mmult = ff;
      end
      2'd1: begin
        mcoef = stage ? lp_a1 : hp_a1;
        mmult = stage ? MW'(ly1) : MW'(hy1);
      end
      default: begin
        mcoef = stage ? lp_a2 : hp_a2;
        mmult = stage ? MW'(ly2) : MW'(hy2);
      end
    endcase
  end

  // rescale and saturate
  always_comb begin
    acc_sh = acc >>> CF;
    if (acc_sh > SMAX) begin
      yv = SMAX[SW-1:0];
    end else if (acc_sh < SMIN) begin
      yv = SMIN[SW-1:0];
    end else begin
      yv = acc_sh[SW-1:0];
    end
  end

  // output gain: mag*28*32767 / (17 << SF)
  always_comb begin
    mag  = cur_x[SW-1] ? (~cur_x + 1'b1) : cur_x;
    m28  = ({mag, 5'b0}) - (SW + 5)'({mag, 2'b0});
    clip = (m28 >= CLIP_LEVEL);
    numw = {m28, 15'b0} - NW'(m28);
    nsh  = numw >> SF;
  end

  rbc_mac #(.CW(CW), .MW(MW), .AW(AW)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctrl),
    .coef (mcoef),
    .mult (mmult),
    .acc  (acc),
    .done (mdone)
  );

  rbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (nsh[NUM_WIDTH-1:0]),
    .quot  (quot),
    .done  (ddone)
  );

  assign out_free = ~m_tvalid | m_tready;
  assign s_tready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = en ? ST_ISSUE : ST_OUT;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (mdone) begin
          if (tc != 2'd2) begin
            state_next = ST_ISSUE;
          end else begin
            state_next = stage ? ST_SCALE : ST_ISSUE;
          end
        end
      end
      ST_SCALE: state_next = clip ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (ddone) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mctrl.start = (state == ST_ISSUE);
    mctrl.clear = (state == ST_ISSUE) && (tc == 2'd0);
    mctrl.sub   = (tc != 2'd0);
    dstart      = (state == ST_SCALE) && !clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      tc       <= '0;
      stage    <= 1'b0;
      hx1 <= '0; hx2 <= '0; hy1 <= '0; hy2 <= '0;
      lx1 <= '0; lx2 <= '0; ly1 <= '0; ly2 <= '0;
    end else begin
      if (m_tvalid && m_tready && !((state == ST_OUT) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            res   <= s_tdata;
            last  <= s_tlast;
            cur_x <= xin;
            tc    <= '0;
            stage <= 1'b0;
          end
        end
        ST_WAIT: begin
          if (mdone) begin
            if (tc != 2'd2) begin
              tc <= tc + 1'b1;
            end else begin
              tc    <= '0;
              cur_x <= yv;
              stage <= 1'b1;
              if (stage) begin
                lx2 <= lx1; lx1 <= cur_x; ly2 <= ly1; ly1 <= yv;
              end else begin
                hx2 <= hx1; hx1 <= cur_x; hy2 <= hy1; hy1 <= yv;
              end
            end
          end
        end
        ST_SCALE: begin
          if (clip) begin
            res <= cur_x[SW-1] ? -16'sd32767 : 16'sd32767;
          end
        end
        ST_DIV: begin
          if (ddone) begin
            res <= cur_x[SW-1] ? -(16'(quot)) : 16'(quot);
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tlast  <= last;
            if (last) begin
              hx1 <= '0; hx2 <= '0; hy1 <= '0; hy2 <= '0;
              lx1 <= '0; lx2 <= '0; ly1 <= '0; ly2 <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
